/* hw/rtl/chbd_pkg.sv */
// ---------------------------------------------------------------------------
// chbd_pkg
// shared types, codes and helpers of the chunked body decoder
// ---------------------------------------------------------------------------
package chbd_pkg;

  localparam int SIZE_BITS = 32;
  localparam int LEN_BITS  = 32;
  localparam int BYTE_BITS = 8;

  localparam logic [BYTE_BITS-1:0] CHAR_CR    = 8'h0d;
  localparam logic [BYTE_BITS-1:0] CHAR_LF    = 8'h0a;
  localparam logic [BYTE_BITS-1:0] CHAR_SEMI  = 8'h3b;
  localparam logic [BYTE_BITS-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_BITS-1:0] CHAR_TAB   = 8'h09;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_DATA    = 3'd1,
    PH_DATA_CR = 3'd2,
    PH_DATA_LF = 3'd3,
    PH_TRAILER = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    PART_LEAD  = 2'd0,
    PART_HEX   = 2'd1,
    PART_TRAIL = 2'd2,
    PART_EXT   = 2'd3
  } part_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_LINE  = 2'd1,
    ERR_CRLF  = 2'd2,
    ERR_LARGE = 2'd3
  } err_t;

  typedef struct packed {
    logic                 data_valid;
    logic [BYTE_BITS-1:0] data_byte;
    logic                 body_done;
    err_t                 error_code;
  } result_t;

  // {is_hex, digit value}
  function automatic logic [4:0] hex_digit(input logic [BYTE_BITS-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

/* hw/rtl/chbd_step.sv */
// ---------------------------------------------------------------------------
// chbd_step
// decoder state registers and the per-byte next-state and result logic
// ---------------------------------------------------------------------------
module chbd_step (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [chbd_pkg::LEN_BITS-1:0]    cfg_wdata,
  input  logic                             step_en,
  input  logic                             start_body,
  input  logic [chbd_pkg::BYTE_BITS-1:0]   in_byte,
  output chbd_pkg::result_t                result
);
  import chbd_pkg::*;

  logic [LEN_BITS-1:0]  max_body_bytes;
  phase_t               phase, phase_next;
  part_t                part, part_next;
  logic                 cr_pending, cr_pending_next;
  logic                 line_bad, line_bad_next;
  logic                 line_has_text, line_has_text_next;
  logic [SIZE_BITS-1:0] chunk_left, chunk_left_next;
  logic [LEN_BITS-1:0]  body_length, body_length_next;
  err_t                 err, err_next;
  logic                 done, done_next;
  logic                 data_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_bytes <= '0;
    end else if (cfg_we) begin
      max_body_bytes <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SIZE;
      part          <= PART_LEAD;
      cr_pending    <= 1'b0;
      line_bad      <= 1'b0;
      line_has_text <= 1'b0;
      chunk_left    <= '0;
      body_length   <= '0;
      err           <= ERR_NONE;
      done          <= 1'b0;
    end else if (step_en) begin
      phase         <= phase_next;
      part          <= part_next;
      cr_pending    <= cr_pending_next;
      line_bad      <= line_bad_next;
      line_has_text <= line_has_text_next;
      chunk_left    <= chunk_left_next;
      body_length   <= body_length_next;
      err           <= err_next;
      done          <= done_next;
    end
  end

  always_comb begin
    logic       is_size;
    logic       is_ws;
    logic [4:0] hx;
    logic [SIZE_BITS-1:0] left_dec;

    // start of a new body clears all decoder state before this byte, but not the limit
    phase_next         = start_body ? PH_SIZE   : phase;
    part_next          = start_body ? PART_LEAD : part;
    cr_pending_next    = start_body ? 1'b0 : cr_pending;
    line_bad_next      = start_body ? 1'b0 : line_bad;
    line_has_text_next = start_body ? 1'b0 : line_has_text;
    chunk_left_next    = start_body ? '0 : chunk_left;
    body_length_next   = start_body ? '0 : body_length;
    err_next           = start_body ? ERR_NONE : err;
    done_next          = start_body ? 1'b0 : done;
    data_valid         = 1'b0;

    is_size  = (phase_next == PH_SIZE);
    is_ws    = (in_byte == CHAR_SPACE) || (in_byte == CHAR_TAB);
    hx       = hex_digit(in_byte);
    left_dec = chunk_left_next - SIZE_BITS'(1);

    if (!done_next && err_next == ERR_NONE) begin
      case (phase_next)
        PH_SIZE, PH_TRAILER: begin
          if (cr_pending_next && in_byte == CHAR_LF) begin
            cr_pending_next = 1'b0;
            if (is_size) begin
              if (!line_has_text_next || line_bad_next) begin
                err_next = ERR_LINE;
              end else if (chunk_left_next == '0) begin
                phase_next = PH_TRAILER;
              end else begin
                phase_next = PH_DATA;
              end
              part_next     = PART_LEAD;
              line_bad_next = 1'b0;
            end else if (!line_has_text_next) begin
              done_next = 1'b1;
            end
            line_has_text_next = 1'b0;
          end else begin
            // a lone cr counts as an ordinary line character
            if (cr_pending_next) begin
              if (is_size) begin
                if (part_next != PART_EXT) begin
                  line_bad_next = 1'b1;
                end
              end else begin
                line_has_text_next = 1'b1;
              end
            end
            if (in_byte == CHAR_CR) begin
              cr_pending_next = 1'b1;
            end else begin
              cr_pending_next = 1'b0;
              if (!is_size) begin
                line_has_text_next = 1'b1;
              end else if (part_next != PART_EXT) begin
                if (in_byte == CHAR_SEMI) begin
                  part_next = PART_EXT;
                end else if (is_ws) begin
                  if (part_next == PART_HEX) begin
                    part_next = PART_TRAIL;
                  end
                end else if (!hx[4] || part_next == PART_TRAIL) begin
                  line_bad_next = 1'b1;
                end else begin
                  part_next          = PART_HEX;
                  line_has_text_next = 1'b1;
                  // size no longer fits once a nonzero top nibble shifts out
                  if (chunk_left_next[SIZE_BITS-1 -: 4] != 4'd0) begin
                    line_bad_next = 1'b1;
                  end
                  chunk_left_next = {chunk_left_next[SIZE_BITS-5:0], hx[3:0]};
                end
              end
            end
          end
        end
        PH_DATA: begin
          data_valid = 1'b1;
          if (body_length_next != '1) begin
            body_length_next = body_length_next + LEN_BITS'(1);
          end
          chunk_left_next = left_dec;
          if (left_dec == '0) begin
            phase_next = PH_DATA_CR;
            if (max_body_bytes != '0 && body_length_next > max_body_bytes) begin
              err_next = ERR_LARGE;
            end
          end
        end
        PH_DATA_CR: begin
          cr_pending_next = (in_byte == CHAR_CR);
          phase_next      = PH_DATA_LF;
        end
        PH_DATA_LF: begin
          if (cr_pending_next && in_byte == CHAR_LF) begin
            phase_next = PH_SIZE;
          end else begin
            err_next = ERR_CRLF;
          end
          cr_pending_next = 1'b0;
        end
        default: begin
          phase_next = PH_SIZE;
        end
      endcase
    end

    result.data_valid = data_valid;
    result.data_byte  = data_valid ? in_byte : '0;
    result.body_done  = done_next;
    result.error_code = err_next;
  end

`ifndef SYNTHESIS
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (err != ERR_NONE && !(step_en && start_body)) |=> err == $past(err))
    else $error("error status changed without a new body");

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (done && !(step_en && start_body)) |=> done)
    else $error("done flag dropped without a new body");

  a_data_left: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> chunk_left != '0)
    else $error("data phase with no bytes left in chunk");

  a_valid_phase: assert property (@(posedge clk) disable iff (rst)
    (step_en && result.data_valid) |-> (!start_body && phase == PH_DATA && !done
                                        && err == ERR_NONE))
    else $error("payload byte passed outside the data phase");
`endif

endmodule

/* hw/rtl/chbd_out_reg.sv */
// ---------------------------------------------------------------------------
// chbd_out_reg
// result register on the master side of the decoder
// ---------------------------------------------------------------------------
module chbd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  chbd_pkg::result_t result,
  output logic              can_load,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // data_byte[7:0], body_done[8], error_code[10:9]
  output logic              m_axis_tuser    // data_valid
);
  import chbd_pkg::*;

  logic    out_valid;
  result_t out_res;

  assign can_load = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.data_valid;
  assign m_axis_tdata  = {5'd0, out_res.error_code, out_res.body_done, out_res.data_byte};

endmodule

/* hw/rtl/http_chunked_body_decoder_core.sv */
// ---------------------------------------------------------------------------
// http_chunked_body_decoder_core
// de-chunks an http chunked message body, one byte per transaction
// ---------------------------------------------------------------------------
//  channel   dir  handshake              content
//  s_axis    in   tvalid/tready          tdata[7:0] in_byte, tuser start_body
//  m_axis    out  tvalid/tready          tdata data_byte/body_done/error_code,
//                                        tuser data_valid
//  cfg       in   cfg_we                 cfg_wdata max_body_bytes
//
//  one transaction in, one out; a byte can be accepted every cycle while m_axis is not stalled
//  each byte passes the input register, then the step logic into the result register
//  the step logic (32-bit size shift/decrement, length increment and limit compare)
//  sets the cycle time
//  rst is synchronous: clears state and the limit register, no clearing pass
//  a stall on m_axis holds the result register and backs up into s_axis tready
module http_chunked_body_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,      // max_body_bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte[7:0]
  input  logic        s_axis_tuser,   // start_body
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // data_byte[7:0], body_done[8], error_code[10:9]
  output logic        m_axis_tuser    // data_valid
);
  import chbd_pkg::*;

  logic                 in_valid;
  logic                 in_start;
  logic [BYTE_BITS-1:0] in_byte;
  logic                 can_load;
  logic                 advance;
  result_t              result;

  assign advance       = in_valid && can_load;
  assign s_axis_tready = !in_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_start <= s_axis_tuser;
      in_byte  <= s_axis_tdata;
    end
  end

  chbd_step u_step (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .step_en    (advance),
    .start_body (in_start),
    .in_byte    (in_byte),
    .result     (result)
  );

  chbd_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (advance),
    .result        (result),
    .can_load      (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* tb/tb_http_chunked_body_decoder_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_http_chunked_body_decoder_core
// self-checking bench for the chunked body decoder: a short table of
// hand-built bodies, then random well-formed and broken bodies under several
// body limits, with bursty input and a stalling output, every result compared
// against a typed table value or else a cycle-free decoder model in the bench
// ---------------------------------------------------------------------------
module tb_http_chunked_body_decoder_core;
  import chbd_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int WD_LIMIT    = 2000;
  localparam int PHASE_BYTES = 345;
  localparam int DRAIN_CYCLES = 8;
  localparam int DIR_N       = 25;

  typedef enum int {
    FL_NONE, FL_JUNK, FL_LONE_CR, FL_LATE_HEX, FL_EMPTY, FL_OVERFLOW,
    FL_NO_CRLF, FL_CUT, FL_HUGE, FL_NOISE
  } flaw_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

  typedef struct packed {
    logic       start;
    logic [7:0] c;
    logic       typed;
    result_t    want;
  } dir_row_t;

  localparam result_t R_NONE  = '{1'b0, 8'h00, 1'b0, ERR_NONE};
  localparam result_t R_FF    = '{1'b1, 8'hff, 1'b0, ERR_NONE};
  localparam result_t R_ZERO  = '{1'b1, 8'h00, 1'b0, ERR_NONE};
  localparam result_t R_DONE  = '{1'b0, 8'h00, 1'b1, ERR_NONE};
  localparam result_t R_ELINE = '{1'b0, 8'h00, 1'b0, ERR_LINE};
  localparam result_t R_ECRLF = '{1'b0, 8'h00, 1'b0, ERR_CRLF};

  localparam dir_row_t DIR_TAB [DIR_N] = '{
    // first body without a start flag: one byte chunk, zero chunk with extension
    '{1'b0, "1",     1'b1, R_NONE},
    '{1'b0, CHAR_CR, 1'b0, R_NONE},
    '{1'b0, CHAR_LF, 1'b0, R_NONE},
    '{1'b0, 8'hff,   1'b1, R_FF},
    '{1'b0, CHAR_CR, 1'b0, R_NONE},
    '{1'b0, CHAR_LF, 1'b0, R_NONE},
    '{1'b0, "0",     1'b0, R_NONE},
    '{1'b0, CHAR_SEMI, 1'b0, R_NONE},
    '{1'b0, 8'h80,   1'b0, R_NONE},
    '{1'b0, CHAR_CR, 1'b0, R_NONE},
    '{1'b0, CHAR_LF, 1'b0, R_NONE},
    '{1'b0, CHAR_CR, 1'b0, R_NONE},
    '{1'b0, CHAR_LF, 1'b1, R_DONE},
    '{1'b0, "A",     1'b1, R_DONE},
    // size line holding only whitespace
    '{1'b1, CHAR_TAB, 1'b0, R_NONE},
    '{1'b0, CHAR_CR, 1'b0, R_NONE},
    '{1'b0, CHAR_LF, 1'b1, R_ELINE},
    '{1'b0, 8'h00,   1'b1, R_ELINE},
    // chunk followed by CR and a wrong byte
    '{1'b1, "1",     1'b0, R_NONE},
    '{1'b0, CHAR_CR, 1'b0, R_NONE},
    '{1'b0, CHAR_LF, 1'b0, R_NONE},
    '{1'b0, 8'h00,   1'b1, R_ZERO},
    '{1'b0, CHAR_CR, 1'b0, R_NONE},
    '{1'b0, "x",     1'b1, R_ECRLF},
    '{1'b0, CHAR_CR, 1'b1, R_ECRLF}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // in_byte[7:0]
  logic        s_axis_tuser = 1'b0;  // start_body
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // data_byte[7:0], body_done[8], error_code[10:9]
  logic        m_axis_tuser;         // data_valid

  http_chunked_body_decoder_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // decoder model state
  phase_t               dec_phase = PH_SIZE;
  part_t                dec_part  = PART_LEAD;
  logic                 dec_cr    = 1'b0;
  logic                 dec_bad   = 1'b0;
  logic                 dec_text  = 1'b0;
  logic [SIZE_BITS-1:0] dec_left  = '0;
  logic [LEN_BITS-1:0]  dec_len   = '0;
  err_t                 dec_err   = ERR_NONE;
  logic                 dec_done  = 1'b0;
  logic [31:0]          body_limit = '0;

  result_t       exp_q[$];
  logic [8:0]    pend_q[$];   // {start_body, in_byte}
  result_t       last_res = R_NONE;
  int n_fail = 0, n_sent = 0, n_payload = 0, n_done = 0;
  int n_err [4] = '{0, 0, 0, 0};
  int idle_cycles = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int rx_run = 0;

  function automatic int hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  function automatic void size_char(input logic [7:0] c);
    int d;
    d = hex_val(c);
    if (dec_part == PART_EXT) return;
    if (c == CHAR_SEMI) begin
      dec_part = PART_EXT;
      return;
    end
    if (c == CHAR_SPACE || c == CHAR_TAB) begin
      if (dec_part == PART_HEX) dec_part = PART_TRAIL;
      return;
    end
    if (d < 0 || dec_part == PART_TRAIL) begin
      dec_bad = 1'b1;
      return;
    end
    dec_part = PART_HEX;
    dec_text = 1'b1;
    // a nonzero top nibble would be shifted out
    if (dec_left[SIZE_BITS-1 -: 4] != 4'd0) dec_bad = 1'b1;
    dec_left = {dec_left[SIZE_BITS-5:0], 4'(d)};
  endfunction

  // size and trailer line bytes, with CR LF detection
  function automatic void line_char(input logic [7:0] c, input logic in_size);
    if (dec_cr && c == CHAR_LF) begin
      dec_cr = 1'b0;
      if (in_size) begin
        if (!dec_text || dec_bad) dec_err = ERR_LINE;
        else if (dec_left == '0) dec_phase = PH_TRAILER;
        else dec_phase = PH_DATA;
        dec_part = PART_LEAD;
        dec_bad  = 1'b0;
        dec_text = 1'b0;
      end else begin
        if (!dec_text) dec_done = 1'b1;
        dec_text = 1'b0;
      end
      return;
    end
    if (dec_cr) begin
      if (in_size) size_char(CHAR_CR);
      else dec_text = 1'b1;
    end
    if (c == CHAR_CR) begin
      dec_cr = 1'b1;
    end else begin
      dec_cr = 1'b0;
      if (in_size) size_char(c);
      else dec_text = 1'b1;
    end
  endfunction

  function automatic result_t decode_byte(input logic start, input logic [7:0] c);
    result_t r;
    logic    pass;
    pass = 1'b0;
    if (start) begin
      dec_phase = PH_SIZE;
      dec_part  = PART_LEAD;
      dec_cr    = 1'b0;
      dec_bad   = 1'b0;
      dec_text  = 1'b0;
      dec_left  = '0;
      dec_len   = '0;
      dec_err   = ERR_NONE;
      dec_done  = 1'b0;
    end
    if (!dec_done && dec_err == ERR_NONE) begin
      case (dec_phase)
        PH_SIZE: line_char(c, 1'b1);
        PH_DATA: begin
          pass = 1'b1;
          if (dec_len != '1) dec_len = dec_len + LEN_BITS'(1);
          dec_left = dec_left - SIZE_BITS'(1);
          if (dec_left == '0) begin
            dec_phase = PH_DATA_CR;
            if (body_limit != '0 && dec_len > body_limit) dec_err = ERR_LARGE;
          end
        end
        PH_DATA_CR: begin
          dec_cr    = (c == CHAR_CR);
          dec_phase = PH_DATA_LF;
        end
        PH_DATA_LF: begin
          if (dec_cr && c == CHAR_LF) dec_phase = PH_SIZE;
          else dec_err = ERR_CRLF;
          dec_cr = 1'b0;
        end
        PH_TRAILER: line_char(c, 1'b0);
        default: dec_phase = PH_SIZE;
      endcase
    end
    r.data_valid = pass;
    r.data_byte  = pass ? c : 8'h00;
    r.body_done  = dec_done;
    r.error_code = dec_err;
    return r;
  endfunction

  // ---- body generator ----

  function automatic void put(input logic [7:0] b);
    pend_q.push_back({1'b0, b});
  endfunction

  function automatic logic [7:0] ws_char();
    return ($urandom_range(0, 1) != 0) ? CHAR_SPACE : CHAR_TAB;
  endfunction

  function automatic logic [7:0] any_but(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    while (v == a || v == b) v = 8'($urandom_range(0, 255));
    return v;
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    while (hex_val(v) >= 0 || v == CHAR_SPACE || v == CHAR_TAB || v == CHAR_SEMI ||
           v == CHAR_CR || v == CHAR_LF)
      v = 8'($urandom_range(0, 255));
    return v;
  endfunction

  // lowest nd nibbles of v, top first, random letter case
  function automatic void put_hex(input logic [63:0] v, input int nd);
    int k;
    logic [3:0] n;
    for (k = nd - 1; k >= 0; k--) begin
      n = v[4*k +: 4];
      if (n < 4'd10) put(8'h30 + 8'(n));
      else put((($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + 8'(n) - 8'd10);
    end
  endfunction

  function automatic void put_size_line(input logic [31:0] sz, input flaw_t flaw);
    logic [63:0] v;
    int nd;
    int k;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put(ws_char());
    if (flaw != FL_EMPTY && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) put(8'h30);
    v  = {32'd0, sz};
    nd = 1;
    for (k = 1; k < 8; k++) if ((sz >> (4 * k)) != 0) nd = k + 1;
    if (flaw == FL_OVERFLOW) begin
      nd = $urandom_range(9, 16);
      v  = {$urandom, $urandom};
      v[4*(nd-1) +: 4] = 4'($urandom_range(1, 15));
    end
    if (flaw != FL_EMPTY) put_hex(v, nd);
    case (flaw)
      FL_JUNK: begin
        put(junk_char());
        if ($urandom_range(0, 1) != 0) put_hex(v, 1);
      end
      FL_LONE_CR: begin
        put(CHAR_CR);
        put(any_but(CHAR_LF, CHAR_LF));
      end
      FL_LATE_HEX: begin
        put(ws_char());
        put_hex(64'($urandom_range(0, 15)), 1);
      end
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put(ws_char());
    if ($urandom_range(0, 4) == 0) begin
      put(CHAR_SEMI);
      repeat ($urandom_range(0, 6)) put(any_but(CHAR_CR, CHAR_LF));
    end
    put(CHAR_CR);
    put(CHAR_LF);
  endfunction

  function automatic void gen_body();
    int    first, nch, bad_at, i, sz;
    flaw_t flaw;
    first = pend_q.size();
    flaw  = FL_NONE;
    if ($urandom_range(0, 99) < 25) flaw = flaw_t'($urandom_range(FL_JUNK, FL_NOISE));
    if (flaw == FL_NOISE) begin
      repeat ($urandom_range(4, 16)) put(8'($urandom_range(0, 255)));
    end else begin
      nch    = $urandom_range(0, 4);
      bad_at = $urandom_range(0, nch);
      for (i = 0; i <= nch; i++) begin
        if (i == nch) begin
          // last chunk and trailers
          put_size_line(32'd0, (i == bad_at) ? flaw : FL_NONE);
          repeat ($urandom_range(0, 2)) begin
            repeat ($urandom_range(1, 10)) put(any_but(CHAR_CR, CHAR_CR));
            if ($urandom_range(0, 5) == 0) begin
              put(CHAR_CR);
              put(any_but(CHAR_LF, CHAR_CR));
            end
            put(CHAR_CR);
            put(CHAR_LF);
          end
          put(CHAR_CR);
          put(CHAR_LF);
          break;
        end
        if (i == bad_at && flaw == FL_HUGE) begin
          put_size_line(32'h8000_0000 | $urandom, FL_NONE);
          repeat ($urandom_range(1, 10)) put(8'($urandom_range(0, 255)));
          break;
        end
        sz = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        put_size_line(32'(sz), (i == bad_at) ? flaw : FL_NONE);
        if (i == bad_at && flaw inside {FL_JUNK, FL_LONE_CR, FL_LATE_HEX, FL_EMPTY,
                                        FL_OVERFLOW}) break;
        if (i == bad_at && flaw == FL_CUT) begin
          repeat ($urandom_range(0, sz - 1)) put(8'($urandom_range(0, 255)));
          break;
        end
        repeat (sz) put(8'($urandom_range(0, 255)));
        if (i == bad_at && flaw == FL_NO_CRLF) begin
          case ($urandom_range(0, 2))
            0: begin
              put(CHAR_CR);
              put(any_but(CHAR_LF, CHAR_LF));
            end
            1: begin
              put(any_but(CHAR_CR, CHAR_CR));
              put(CHAR_LF);
            end
            default: begin
              put(CHAR_LF);
              put(CHAR_CR);
            end
          endcase
          break;
        end
        put(CHAR_CR);
        put(CHAR_LF);
      end
    end
    // bytes that should be ignored after an error
    if (flaw != FL_NONE && $urandom_range(0, 1) != 0)
      repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
    if (pend_q.size() > first && $urandom_range(0, 19) != 0) pend_q[first][8] = 1'b1;
  endfunction

  // ---- drivers ----

  task automatic push_byte(input logic st, input logic [7:0] c, input logic typed,
                           input result_t typed_res);
    result_t want;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= st;
    s_axis_tdata  <= c;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    want = decode_byte(st, c);
    if (typed) want = typed_res;
    exp_q.push_back(want);
    n_sent++;
    if (want.body_done && !last_res.body_done) n_done++;
    if (want.error_code != ERR_NONE && last_res.error_code == ERR_NONE) n_err[want.error_code]++;
    last_res = want;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(input logic [31:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    body_limit = v;
  endtask

  // ---- output side: stall pattern, checker, watchdog ----

  always @(posedge clk) begin
    if (rx_run == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_run  <= $urandom_range(16, 160);
    end else begin
      rx_run <= rx_run - 1;
    end
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) != 0);
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 4) == 0);
      default:   m_axis_tready <= (rx_run[2:0] < 3'd5);
    endcase
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : rx_check
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (exp_q.size() == 0) begin
        n_fail++;
        $display("%0t: result with nothing expected, tdata %h tuser %b", $time,
                 m_axis_tdata, m_axis_tuser);
      end else begin
        want = exp_q.pop_front();
        check_field("data_valid", 32'(want.data_valid), 32'(m_axis_tuser));
        check_field("data_byte", 32'(want.data_byte), 32'(m_axis_tdata[7:0]));
        check_field("body_done", 32'(want.body_done), 32'(m_axis_tdata[8]));
        check_field("error_code", 32'(want.error_code), 32'(m_axis_tdata[10:9]));
        if (m_axis_tuser) n_payload++;
      end
    end
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
               WD_LIMIT, exp_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---- stimulus ----

  initial begin
    int   ph;
    int   k;
    int   burst_left;
    logic gaps;
    burst_left = 0;
    @(posedge clk);
    @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < DIR_N; k++)
      push_byte(DIR_TAB[k].start, DIR_TAB[k].c, DIR_TAB[k].typed, DIR_TAB[k].want);

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_limit(32'hffff_ffff);
        1: set_limit(32'($urandom_range(10, 80)));
        2: set_limit(32'd1);
        3: set_limit($urandom);
        default: set_limit(32'd0);
      endcase
      gaps = (ph != 2);
      pend_q.delete();
      while (pend_q.size() < PHASE_BYTES) gen_body();
      for (k = 0; k < pend_q.size(); k++) begin
        if (burst_left == 0) begin
          if (gaps && $urandom_range(0, 3) != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
          end
          burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        push_byte(pend_q[k][8], pend_q[k][7:0], 1'b0, R_NONE);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d bytes decoded under five body limits, %0d payload bytes passed through",
             n_sent, n_payload);
    $display("bodies completed %0d; bad size line %0d, missing crlf %0d, over limit %0d",
             n_done, n_err[ERR_LINE], n_err[ERR_CRLF], n_err[ERR_LARGE]);
    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
